### rtl/mmts_pkg.sv
`default_nettype none
package mmts_pkg;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] push_value;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic signed [31:0] largest;
		logic signed [31:0] smallest;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_word_t;

	typedef struct packed {
		logic start;
		logic pop_check;
		logic scan_step;
		logic scan_commit;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic full;
		logic need_scan;
		logic scan_last;
	} dp_sts_t;

endpackage
`default_nettype wire

### rtl/mmts_ram.sv
`default_nettype none
module mmts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/mmts_ctrl.sv
`default_nettype none
module mmts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [1:0]       req_type,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output mmts_pkg::dp_cmd_t     cmd,
	input  wire mmts_pkg::dp_sts_t sts
);
	import mmts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POP   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       rsp_valid_q;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.start       = req_valid && (state_q == ST_IDLE);
		cmd.pop_check   = (state_q == ST_POP);
		cmd.scan_step   = (state_q == ST_SCAN);
		cmd.scan_commit = (state_q == ST_DRAIN);
		cmd.load_out    = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nx = (req_type == REQ_POP && !sts.fill_zero) ? ST_POP : ST_FIN;
				end
			end
			ST_POP: begin
				state_nx = sts.need_scan ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (cmd.load_out) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/mmts_dp.sv
`default_nettype none
module mmts_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mmts_pkg::req_word_t req_word,
	input  wire mmts_pkg::dp_cmd_t  cmd,
	output mmts_pkg::dp_sts_t       sts,
	output mmts_pkg::rsp_word_t     rsp_word
);
	import mmts_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int FW = $clog2(STACK_DEPTH + 1);

	logic [FW-1:0]      fill_q;
	logic signed [31:0] max_q;
	logic signed [31:0] min_q;
	logic signed [31:0] popped_q;
	logic [1:0]         status_q;
	logic               need_max_q;
	logic               need_min_q;
	logic [AW-1:0]      scan_addr_q;
	logic               rd_valid_q;
	logic signed [31:0] acc_max_q;
	logic signed [31:0] acc_min_q;
	rsp_word_t          rsp_q;

	logic               full;
	logic               fill_zero;
	logic               do_push;
	logic               do_pop;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;
	logic signed [31:0] rd_s;
	logic signed [31:0] acc_max_nx;
	logic signed [31:0] acc_min_nx;

	assign full      = (fill_q == FW'(STACK_DEPTH));
	assign fill_zero = (fill_q == '0);
	assign do_push   = cmd.start && (req_word.req_type == REQ_PUSH) && !full;
	assign do_pop    = cmd.start && (req_word.req_type == REQ_POP) && !fill_zero;
	assign ram_re    = do_pop || cmd.scan_step;
	assign ram_raddr = cmd.scan_step ? scan_addr_q : AW'(fill_q - FW'(1));
	assign rd_s      = $signed(ram_rdata);

	mmts_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (AW'(fill_q)),
		.wdata (req_word.push_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// fold the word read last cycle into the running extremes
	always_comb begin
		acc_max_nx = acc_max_q;
		acc_min_nx = acc_min_q;
		if (rd_valid_q) begin
			if (rd_s > acc_max_q) begin
				acc_max_nx = rd_s;
			end
			if (rd_s < acc_min_q) begin
				acc_min_nx = rd_s;
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.fill_zero = fill_zero;
		sts.full      = full;
		sts.need_scan = !fill_zero && ((rd_s == max_q) || (rd_s == min_q));
		sts.scan_last = (scan_addr_q == AW'(fill_q - FW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			max_q      <= INT_MIN;
			min_q      <= INT_MAX;
			rd_valid_q <= 1'b0;
			need_max_q <= 1'b0;
			need_min_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				unique case (req_word.req_type)
					REQ_PUSH: begin
						if (!full) begin
							fill_q <= fill_q + FW'(1);
							if (req_word.push_value > max_q) begin
								max_q <= req_word.push_value;
							end
							if (req_word.push_value < min_q) begin
								min_q <= req_word.push_value;
							end
						end
					end
					REQ_POP: begin
						if (!fill_zero) begin
							fill_q <= fill_q - FW'(1);
						end
					end
					REQ_CLEAR: begin
						fill_q <= '0;
						max_q  <= INT_MIN;
						min_q  <= INT_MAX;
					end
					default: begin
					end
				endcase
			end
			if (cmd.pop_check) begin
				need_max_q <= (rd_s == max_q);
				need_min_q <= (rd_s == min_q);
				rd_valid_q <= 1'b0;
				// last entry gone: back to sentinels
				if (fill_zero) begin
					max_q <= INT_MIN;
					min_q <= INT_MAX;
				end
			end
			if (cmd.scan_step) begin
				rd_valid_q <= 1'b1;
			end
			if (cmd.scan_commit) begin
				rd_valid_q <= 1'b0;
				if (need_max_q) begin
					max_q <= acc_max_nx;
				end
				if (need_min_q) begin
					min_q <= acc_min_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			popped_q <= '0;
			if (req_word.req_type == REQ_PUSH && full) begin
				status_q <= STS_FULL;
			end else if (req_word.req_type == REQ_POP && fill_zero) begin
				status_q <= STS_EMPTY;
			end else begin
				status_q <= STS_OK;
			end
		end
		if (cmd.pop_check) begin
			popped_q    <= rd_s;
			scan_addr_q <= '0;
			acc_max_q   <= INT_MIN;
			acc_min_q   <= INT_MAX;
		end
		if (cmd.scan_step) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			acc_max_q   <= acc_max_nx;
			acc_min_q   <= acc_min_nx;
		end
		if (cmd.load_out) begin
			rsp_q.popped_value <= popped_q;
			rsp_q.largest      <= max_q;
			rsp_q.smallest     <= min_q;
			rsp_q.is_empty     <= fill_zero;
			rsp_q.status       <= status_q;
		end
	end

	assign rsp_word = rsp_q;

endmodule
`default_nettype wire

### rtl/min_max_tracking_stack_top.sv
`default_nettype none
// channel | valid     | stall     | word
// request | req_valid | req_stall | req_word (req_type, push_value)
// result  | rsp_valid | rsp_stall | rsp_word (popped_value, largest, smallest,
//         |           |           |           is_empty, status)
//
// Push, clear, refused requests and unused codes: accept, then load the result word.
// Pop that leaves both extremes alone, or pops the last entry: one RAM read of
// the top entry, then the result word.
// Pop that removes an extreme with N >= 1 entries left: top read, then a rescan
// that reads the stack RAM one entry a cycle through its single read port.
// Reset clears the fill count and sets the extremes to their sentinels; no
// RAM sweep is needed. One request at a time; a finished word waits in the
// output register while the next request is taken.
module min_max_tracking_stack_top #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire mmts_pkg::req_word_t req_word,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output mmts_pkg::rsp_word_t      rsp_word
);
	import mmts_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mmts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_word.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mmts_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_word (rsp_word)
	);

	a_full_xor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.fill_zero))
		else $error("stack both full and empty");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous still in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || !rsp_stall))
		else $error("result word overwritten while stalled");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !sts.fill_zero)
		else $error("rescan on empty stack");

endmodule
`default_nettype wire
